>>> rtl/core/mrcr_pkg.sv
package mrcr_pkg;

	localparam int MAX_DIM    = 32;
	localparam int WORD_WIDTH = 32;

	localparam int CELLS  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int DIM_W  = 6;
	localparam int POS_W  = 16;
	localparam int STEP_W = $clog2(POS_W + 1);

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_ROTATE = 2'd2;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic AXIS_ROW = 1'b0;
	localparam logic AXIS_COL = 1'b1;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_BAD_LINE = 3'd1;
	localparam logic [2:0] STAT_ZERO_POS = 3'd2;
	localparam logic [2:0] STAT_BAD_DIR  = 3'd3;
	localparam logic [2:0] STAT_BAD_ADDR = 3'd4;

	typedef logic [WORD_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [4:0]         row_pos;
		logic [4:0]         col_pos;
		logic signed [31:0] write_value;
		logic               axis;
		logic [5:0]         line_index;
		logic [1:0]         direction;
		logic [15:0]        positions;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [2:0]         status;
	} out_item_t;

	typedef struct packed {
		logic  shift;
		word_t tail;
	} cell_ctrl_t;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
	endfunction

	function automatic word_t to_word(input logic signed [31:0] v);
		return WORD_WIDTH'(v);
	endfunction

	function automatic logic signed [31:0] from_word(input word_t w);
		return 32'(signed'(w));
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		if ({1'b0, v} > (DIM_W + 1)'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

endpackage

>>> rtl/core/matrix_row_column_rotator.sv
// A matrix of up to MAX_DIM x MAX_DIM signed words in one RAM port pair. Each input beat
// writes an element, reads one, or circularly rotates a row or a column of the region in
// use, and gives one result beat with read data and status; a beat of the spare mode only
// gives its result. A rotation first reduces the position count modulo the line length in
// a bit-serial unit, then loads the line into a chain of cells one word per cycle through
// the RAM read port, shifts the chain k times for the reduced count k (k from 0 to n-1 for
// a line of n words) and writes it back through the RAM write port. Elements that were
// never written read back as undefined data. A new beat is accepted once the previous
// result has been handed to the output register.
module matrix_row_column_rotator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mrcr_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mrcr_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [5:0]           cfg_data
);
	import mrcr_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_RDWAIT = 7'b0000010,
		S_MOD    = 7'b0000100,
		S_LOAD   = 7'b0001000,
		S_ROT    = 7'b0010000,
		S_STORE  = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [DIM_W-1:0] n_q;
	logic [DIM_W-1:0] line_q;
	logic [DIM_W-1:0] cnt_q;
	logic [DIM_W-1:0] rot_q;
	logic             axis_q;
	logic             left_q;
	logic             rd_pend_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic             accept;
	logic             addr_ok;
	logic [DIM_W-1:0] rot_len;
	logic [DIM_W-1:0] rot_limit;
	logic [2:0]       rot_status;
	logic [ADDR_W-1:0] elem_a;
	logic [ADDR_W-1:0] line_a;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	word_t             ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	word_t             ram_rdata;

	logic              mod_start;
	logic              mod_done;
	logic [DIM_W-1:0]  mod_rem;

	cell_ctrl_t        cell_ctrl;
	word_t             cell_val [MAX_DIM];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign addr_ok = ({1'b0, in_data.row_pos} < rows_q) && ({1'b0, in_data.col_pos} < cols_q);
	assign elem_a  = elem_addr({1'b0, in_data.row_pos}, {1'b0, in_data.col_pos});
	assign line_a  = (axis_q == AXIS_ROW) ? elem_addr(line_q, cnt_q) : elem_addr(cnt_q, line_q);

	assign rot_len   = (in_data.axis == AXIS_COL) ? rows_q : cols_q;
	assign rot_limit = (in_data.axis == AXIS_COL) ? cols_q : rows_q;

	always_comb begin
		if (in_data.positions == '0)
			rot_status = STAT_ZERO_POS;
		else if (in_data.line_index == '0 || in_data.line_index > rot_limit)
			rot_status = STAT_BAD_LINE;
		else if (in_data.axis == AXIS_ROW &&
			!(in_data.direction == DIR_RIGHT || in_data.direction == DIR_LEFT))
			rot_status = STAT_BAD_DIR;
		else if (in_data.axis == AXIS_COL &&
			!(in_data.direction == DIR_UP || in_data.direction == DIR_DOWN))
			rot_status = STAT_BAD_DIR;
		else
			rot_status = STAT_OK;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = elem_a;
		ram_wdata = to_word(in_data.write_value);
		ram_re    = 1'b0;
		ram_raddr = elem_a;
		mod_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && addr_ok && in_data.mode == MODE_WRITE)
					ram_we = 1'b1;
				if (accept && addr_ok && in_data.mode == MODE_READ)
					ram_re = 1'b1;
				if (accept && in_data.mode == MODE_ROTATE && rot_status == STAT_OK)
					mod_start = 1'b1;
			end
			S_LOAD: begin
				ram_raddr = line_a;
				ram_re    = (cnt_q != n_q);
			end
			S_STORE: begin
				ram_we    = 1'b1;
				ram_waddr = line_a;
				ram_wdata = cell_val[0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cell_ctrl.tail  = (state_q == S_LOAD) ? ram_rdata : cell_val[0];
		cell_ctrl.shift = (state_q == S_LOAD && rd_pend_q) ||
			(state_q == S_ROT && rot_q != '0) || (state_q == S_STORE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= clamp_dim(DIM_W'(32));
			cols_q <= clamp_dim(DIM_W'(32));
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS)
				rows_q <= clamp_dim(cfg_data);
			else
				cols_q <= clamp_dim(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			rd_pend_q <= ram_re && (state_q == S_LOAD);
			if (state_q == S_RESP)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.mode == MODE_READ && addr_ok)
							state_q <= S_RDWAIT;
						else if (in_data.mode == MODE_ROTATE && rot_status == STAT_OK)
							state_q <= S_MOD;
						else
							state_q <= S_RESP;
					end
				end
				S_RDWAIT: state_q <= S_RESP;
				S_MOD: begin
					if (mod_done)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (cnt_q == n_q)
						state_q <= S_ROT;
				end
				S_ROT: begin
					if (rot_q == '0)
						state_q <= S_STORE;
				end
				S_STORE: begin
					if (cnt_q == n_q - DIM_W'(1))
						state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q.read_value <= '0;
				if (in_data.mode == MODE_WRITE || in_data.mode == MODE_READ)
					res_q.status <= addr_ok ? STAT_OK : STAT_BAD_ADDR;
				else if (in_data.mode == MODE_ROTATE)
					res_q.status <= rot_status;
				else
					res_q.status <= STAT_OK;
				n_q    <= rot_len;
				line_q <= in_data.line_index - DIM_W'(1);
				axis_q <= in_data.axis;
				left_q <= (in_data.direction == DIR_UP) || (in_data.direction == DIR_LEFT);
				cnt_q  <= '0;
			end
			S_RDWAIT: res_q.read_value <= from_word(ram_rdata);
			S_MOD: begin
				if (mod_done) begin
					if (left_q || mod_rem == '0)
						rot_q <= mod_rem;
					else
						rot_q <= n_q - mod_rem;
				end
			end
			S_LOAD: begin
				if (cnt_q != n_q)
					cnt_q <= cnt_q + DIM_W'(1);
				else
					cnt_q <= '0;
			end
			S_ROT: begin
				if (rot_q != '0)
					rot_q <= rot_q - DIM_W'(1);
			end
			S_STORE: cnt_q <= cnt_q + DIM_W'(1);
			S_RESP: begin
				if (!out_valid_q || out_ready)
					out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	mrcr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (in_data.positions),
		.divisor   (rot_len),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	mrcr_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
		logic  last_here;
		word_t right_word;

		assign last_here = (n_q == DIM_W'(i + 1));
		if (i == MAX_DIM - 1) begin : g_end
			assign right_word = cell_ctrl.tail;
		end else begin : g_mid
			assign right_word = cell_val[i+1];
		end

		mrcr_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.is_last  (last_here),
			.right_in (right_word),
			.value    (cell_val[i])
		);
	end

	// A line is only fetched while it is being loaded into the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> state_q == S_LOAD)
		else $error("line read returned outside the load phase");

	// The matrix changes only through an accepted write beat or the store phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (accept && in_data.mode == MODE_WRITE) || state_q == S_STORE)
		else $error("unexpected matrix write");

	// One item at a time: in the cycle after an accepted beat the input is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input reopened right after a beat");

endmodule

>>> rtl/core/mrcr_ram.sv
module mrcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/mrcr_mod.sv
module mrcr_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mrcr_pkg::POS_W-1:0]    dividend,
	input  logic [mrcr_pkg::DIM_W-1:0]    divisor,
	output logic                          done,
	output logic [mrcr_pkg::DIM_W-1:0]    remainder
);
	import mrcr_pkg::*;

	logic [STEP_W-1:0] steps_q;
	logic [POS_W-1:0]  num_q;
	logic [DIM_W-1:0]  div_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W:0]    trial;

	assign trial = {rem_q, num_q[POS_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(POS_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (steps_q != '0) begin
			num_q <= {num_q[POS_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				rem_q <= DIM_W'(trial - {1'b0, div_q});
			else
				rem_q <= DIM_W'(trial);
		end
	end

	assign done      = (steps_q == '0);
	assign remainder = rem_q;

endmodule

>>> rtl/core/mrcr_cell.sv
module mrcr_cell (
	input  logic                 clk,
	input  mrcr_pkg::cell_ctrl_t ctrl,
	input  logic                 is_last,
	input  mrcr_pkg::word_t      right_in,
	output mrcr_pkg::word_t      value
);
	import mrcr_pkg::*;

	word_t value_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift)
			value_q <= is_last ? ctrl.tail : right_in;
	end

	assign value = value_q;

endmodule

>>> sim/matrix_row_column_rotator_checker.sv
module matrix_row_column_rotator_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  mrcr_pkg::in_item_t         in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  mrcr_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [5:0]                 cfg_data,
	output int                         mismatches,
	output int                         outstanding,
	output logic [mrcr_pkg::DIM_W-1:0] rows_active,
	output logic [mrcr_pkg::DIM_W-1:0] cols_active
);
	timeunit 1ns;
	timeprecision 1ps;

	import mrcr_pkg::*;

	word_t            grid [CELLS];
	out_item_t        pending_results [$];
	out_item_t        oldest;
	logic [DIM_W-1:0] grid_rows;
	logic [DIM_W-1:0] grid_cols;
	int               fail_count = 0;

	function automatic logic [DIM_W-1:0] saturate_dim(input logic [5:0] v);
		if (v == '0)
			return DIM_W'(1);
		if (int'(v) > MAX_DIM)
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic void rotate_line(input logic axis, input int line,
		input logic [1:0] dir, input int k);
		word_t line_buf [MAX_DIM];
		int    n;
		int    src;
		n = (axis == AXIS_ROW) ? int'(grid_cols) : int'(grid_rows);
		for (int j = 0; j < n; j++) begin
			if (dir == DIR_RIGHT || dir == DIR_DOWN)
				src = (j + n - k) % n;
			else
				src = (j + k) % n;
			line_buf[j] = (axis == AXIS_ROW) ? grid[line * MAX_DIM + src] : grid[src * MAX_DIM + line];
		end
		for (int j = 0; j < n; j++) begin
			if (axis == AXIS_ROW)
				grid[line * MAX_DIM + j] = line_buf[j];
			else
				grid[j * MAX_DIM + line] = line_buf[j];
		end
	endfunction

	function automatic out_item_t apply_command(input in_item_t cmd);
		out_item_t res;
		int        addr;
		int        len;
		int        limit;
		logic      row_dir;
		res = '0;
		case (cmd.mode)
			MODE_WRITE, MODE_READ: begin
				if (cmd.row_pos >= grid_rows || cmd.col_pos >= grid_cols) begin
					res.status = STAT_BAD_ADDR;
				end else begin
					addr = int'(cmd.row_pos) * MAX_DIM + int'(cmd.col_pos);
					if (cmd.mode == MODE_WRITE)
						grid[addr] = WORD_WIDTH'(cmd.write_value);
					else
						res.read_value = 32'(signed'(grid[addr]));
				end
			end
			MODE_ROTATE: begin
				len = (cmd.axis == AXIS_ROW) ? int'(grid_cols) : int'(grid_rows);
				limit = (cmd.axis == AXIS_ROW) ? int'(grid_rows) : int'(grid_cols);
				row_dir = (cmd.direction == DIR_RIGHT || cmd.direction == DIR_LEFT);
				if (cmd.positions == '0)
					res.status = STAT_ZERO_POS;
				else if (cmd.line_index == '0 || int'(cmd.line_index) > limit)
					res.status = STAT_BAD_LINE;
				else if ((cmd.axis == AXIS_ROW) != row_dir)
					res.status = STAT_BAD_DIR;
				else
					rotate_line(cmd.axis, int'(cmd.line_index) - 1, cmd.direction,
						int'(cmd.positions) % len);
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows = DIM_W'(MAX_DIM);
			grid_cols = DIM_W'(MAX_DIM);
			pending_results.delete();
			foreach (grid[i])
				grid[i] = '0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					$error("result beat with nothing outstanding: read_value %0d status %0d",
						out_data.read_value, out_data.status);
				end else begin
					oldest = pending_results.pop_front();
					if (out_data.read_value !== oldest.read_value) begin
						fail_count++;
						$error("read_value: expected %0d, got %0d", oldest.read_value,
							out_data.read_value);
					end
					if (out_data.status !== oldest.status) begin
						fail_count++;
						$error("status: expected %0d, got %0d", oldest.status, out_data.status);
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_command(in_data));
			if (cfg_we) begin
				if (cfg_index == CFG_ROWS)
					grid_rows = saturate_dim(cfg_data);
				else
					grid_cols = saturate_dim(cfg_data);
			end
		end
		outstanding <= pending_results.size();
		mismatches <= fail_count;
		rows_active <= grid_rows;
		cols_active <= grid_cols;
	end

endmodule

>>> sim/tb_matrix_row_column_rotator.sv
module tb_matrix_row_column_rotator;
	timeunit 1ns;
	timeprecision 1ps;

	import mrcr_pkg::*;

	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int         QUIET_LIMIT = 4000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
	typedef enum int {BREAK_ZERO_COUNT, BREAK_LINE, BREAK_DIRECTION} rotate_fault_e;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	in_item_t         in_data   = '0;
	logic             out_ready = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = 1'b0;
	logic [5:0]       cfg_data  = '0;
	logic             in_ready;
	logic             out_valid;
	out_item_t        out_data;
	int               mismatches;
	int               outstanding;
	logic [DIM_W-1:0] rows_active;
	logic [DIM_W-1:0] cols_active;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int quiet_cycles  = 0;
	bit holds_value [MAX_DIM][MAX_DIM];

	matrix_row_column_rotator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix_row_column_rotator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.rows_active (rows_active),
		.cols_active (cols_active)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("matrix_row_column_rotator verification failed");
				$finish;
			end
		end
	end

	// Mirrors which cells hold a written value, so that reads never touch undefined data.
	function automatic void track_cells(input in_item_t cmd);
		bit line_copy [MAX_DIM];
		int len;
		int limit;
		int k;
		int src;
		len = (cmd.axis == AXIS_ROW) ? int'(cols_active) : int'(rows_active);
		limit = (cmd.axis == AXIS_ROW) ? int'(rows_active) : int'(cols_active);
		if (cmd.mode == MODE_WRITE && cmd.row_pos < rows_active && cmd.col_pos < cols_active) begin
			holds_value[cmd.row_pos][cmd.col_pos] = 1'b1;
		end else if (cmd.mode == MODE_ROTATE && cmd.positions != '0 && cmd.line_index != '0
			&& int'(cmd.line_index) <= limit
			&& ((cmd.axis == AXIS_ROW) == (cmd.direction == DIR_RIGHT || cmd.direction == DIR_LEFT)))
		begin
			k = int'(cmd.positions) % len;
			for (int j = 0; j < len; j++) begin
				if (cmd.direction == DIR_RIGHT || cmd.direction == DIR_DOWN)
					src = (j + len - k) % len;
				else
					src = (j + k) % len;
				if (cmd.axis == AXIS_ROW)
					line_copy[j] = holds_value[cmd.line_index - 1][src];
				else
					line_copy[j] = holds_value[src][cmd.line_index - 1];
			end
			for (int j = 0; j < len; j++) begin
				if (cmd.axis == AXIS_ROW)
					holds_value[cmd.line_index - 1][j] = line_copy[j];
				else
					holds_value[j][cmd.line_index - 1] = line_copy[j];
			end
		end
	endfunction

	function automatic in_item_t command(input logic [1:0] mode, input int row, input int col,
		input int value, input logic axis, input int line, input logic [1:0] dir, input int count);
		in_item_t cmd;
		cmd = $bits(in_item_t)'({$urandom, $urandom, $urandom});
		cmd.mode = mode;
		cmd.row_pos = 5'(row);
		cmd.col_pos = 5'(col);
		cmd.write_value = value;
		cmd.axis = axis;
		cmd.line_index = 6'(line);
		cmd.direction = dir;
		cmd.positions = 16'(count);
		return cmd;
	endfunction

	function automatic in_item_t next_command();
		in_item_t      cmd;
		int            pick;
		int            rows;
		int            cols;
		int            len;
		int            limit;
		rotate_fault_e fault;
		cmd = $bits(in_item_t)'({$urandom, $urandom, $urandom});
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: cmd.write_value = 32'sh8000_0000;
				1: cmd.write_value = 32'sh7fff_ffff;
				2: cmd.write_value = -32'sd1;
				default: cmd.write_value = '0;
			endcase
		end
		rows = int'(rows_active);
		cols = int'(cols_active);
		len = (cmd.axis == AXIS_ROW) ? cols : rows;
		limit = (cmd.axis == AXIS_ROW) ? rows : cols;
		pick = $urandom_range(99);
		if (pick < 30) begin
			cmd.mode = MODE_WRITE;
			cmd.row_pos = 5'($urandom_range(rows - 1));
			cmd.col_pos = 5'($urandom_range(cols - 1));
		end else if (pick < 55) begin
			cmd.mode = MODE_WRITE;
			for (int t = 0; t < 16 && cmd.mode != MODE_READ; t++) begin
				cmd.row_pos = 5'($urandom_range(rows - 1));
				cmd.col_pos = 5'($urandom_range(cols - 1));
				if (holds_value[cmd.row_pos][cmd.col_pos])
					cmd.mode = MODE_READ;
			end
		end else if (pick < 78) begin
			cmd.mode = MODE_ROTATE;
			cmd.line_index = 6'($urandom_range(1, limit));
			if (cmd.axis == AXIS_ROW)
				cmd.direction = $urandom_range(1) ? DIR_RIGHT : DIR_LEFT;
			else
				cmd.direction = $urandom_range(1) ? DIR_UP : DIR_DOWN;
			if ($urandom_range(3) == 0)
				cmd.positions = 16'($urandom_range(1, 65535));
			else
				cmd.positions = 16'($urandom_range(1, 2 * len + 1));
		end else if (pick < 90) begin
			cmd.mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
			if (cmd.mode == MODE_READ && cmd.row_pos < rows && cmd.col_pos < cols
				&& !holds_value[cmd.row_pos][cmd.col_pos])
				cmd.mode = MODE_WRITE;
		end else if (pick < 97) begin
			cmd.mode = MODE_ROTATE;
			fault = rotate_fault_e'($urandom_range(2));
			case (fault)
				BREAK_ZERO_COUNT: cmd.positions = '0;
				BREAK_LINE: cmd.line_index = 6'($urandom_range(1) ? 0 : $urandom_range(limit + 1, 63));
				default: begin
					if (cmd.positions == '0)
						cmd.positions = 16'd1;
					cmd.line_index = 6'($urandom_range(1, limit));
					if (cmd.axis == AXIS_ROW)
						cmd.direction = $urandom_range(1) ? DIR_UP : DIR_DOWN;
					else
						cmd.direction = $urandom_range(1) ? DIR_RIGHT : DIR_LEFT;
				end
			endcase
		end else begin
			cmd.mode = MODE_SPARE;
		end
		return cmd;
	endfunction

	task automatic issue(input in_item_t cmd);
		int gap;
		track_cells(cmd);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		in_data <= cmd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_dims(input int rows_raw, input int cols_raw);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data <= 6'(rows_raw);
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data <= 6'(cols_raw);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int rows_raw, input int cols_raw, input idle_mode_e idle,
		input int count);
		set_dims(rows_raw, cols_raw);
		send_idle_pct = (idle == IDLE_SENDER) ? 57 : (idle == IDLE_BOTH) ? 33 : 0;
		stall_pct <= (idle == IDLE_RECEIVER) ? 57 : (idle == IDLE_BOTH) ? 33 : 0;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			issue(next_command());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(command(MODE_WRITE, 0, 0, 32'h8000_0000, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_WRITE, 0, 1, 32'h7fff_ffff, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_WRITE, 0, 31, -1, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_WRITE, 31, 31, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_WRITE, 31, 0, 1, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 0, 0, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 0, 1, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 31, 31, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 1, DIR_RIGHT, 1));
		issue(command(MODE_READ, 0, 0, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 1, DIR_LEFT, 65));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_COL, 1, DIR_UP, 65535));
		issue(command(MODE_READ, 0, 0, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 1, 0, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_COL, 32, DIR_DOWN, 32));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 1, DIR_RIGHT, 0));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 0, DIR_UP, 3));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_COL, 33, DIR_UP, 3));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 63, DIR_UP, 0));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_ROW, 2, DIR_UP, 5));
		issue(command(MODE_ROTATE, 0, 0, 0, AXIS_COL, 2, DIR_LEFT, 5));
		issue(command(MODE_SPARE, 31, 31, -1, AXIS_COL, 63, DIR_LEFT, 65535));

		set_dims(3, 5);
		issue(command(MODE_WRITE, 3, 0, 7, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 0, 5, 0, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_WRITE, 2, 4, -7, AXIS_ROW, 1, DIR_UP, 1));
		issue(command(MODE_READ, 2, 4, 0, AXIS_ROW, 1, DIR_UP, 1));

		run_phase(63, 40, IDLE_NONE, 175);
		run_phase(0, 7, IDLE_SENDER, 175);
		run_phase(5, 1, IDLE_RECEIVER, 175);
		run_phase(32, 32, IDLE_BOTH, 175);
		run_phase(2, 32, IDLE_NONE, 175);
		run_phase(17, 3, IDLE_SENDER, 175);
		run_phase(32, 0, IDLE_RECEIVER, 175);
		run_phase(8, 33, IDLE_BOTH, 175);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("matrix_row_column_rotator verification clean");
		else
			$display("matrix_row_column_rotator verification failed");
		$finish;
	end

endmodule
